[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, held off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

[rtl/zacw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zacw_pkg
// Shared constants, codes and types of the single-wire temperature receiver.
// ----------------------------------------------------------------------------
package zacw_pkg;

    // Packet and counter geometry
    localparam int BITS_PER_PACKET    = 9;
    localparam int TICK_COUNTER_WIDTH = 16;
    localparam int BIT_INDEX_WIDTH    = $clog2(BITS_PER_PACKET + 1);

    // Configuration registers
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETTLE       = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SAMPLE_DELAY = 1'b1;
    localparam logic [CFG_WIDTH-1:0] SETTLE_RESET       = 16'd60;
    localparam logic [CFG_WIDTH-1:0] SAMPLE_DELAY_RESET = 16'd60;

    localparam int CMP_WIDTH = (TICK_COUNTER_WIDTH > CFG_WIDTH) ?
                               TICK_COUNTER_WIDTH : CFG_WIDTH;

    // Result payload
    localparam int BYTE_WIDTH = 8;
    localparam int RAW_WIDTH  = 16;
    localparam int TEMP_WIDTH = 21;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // Temperature arithmetic: raw*20000/2047 = raw*9 + raw*1577/2047.
    // The fraction part uses a reciprocal of 2^32/2047 and one correction.
    localparam int PROD1_WIDTH = 27;
    localparam int RECIP_WIDTH = 22;
    localparam int PROD2_WIDTH = PROD1_WIDTH + RECIP_WIDTH;
    localparam int RECIP_SHIFT = 32;
    localparam int QUOT_WIDTH  = PROD2_WIDTH - RECIP_SHIFT;
    localparam int WHOLE_WIDTH = 20;
    localparam int DIV_SHIFT   = 11;
    localparam logic [PROD1_WIDTH-1:0] SPAN_FRAC = 27'd1577;
    localparam logic [RECIP_WIDTH-1:0] RECIP     = 22'd2098176;
    localparam logic [PROD1_WIDTH:0]   DIVISOR   = 28'd2047;
    localparam logic [TEMP_WIDTH-1:0]  OFFSET    = 21'd5000;

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_SETTLE    = 7'b0000010,
        PH_SYNC_HIGH = 7'b0000100,
        PH_SYNC_LOW  = 7'b0001000,
        PH_BIT_HIGH  = 7'b0010000,
        PH_DELAY     = 7'b0100000,
        PH_BIT_LOW   = 7'b1000000
    } phase_t;

    // One tick's word from the front to the back
    typedef struct packed {
        logic                 power;
        logic                 done;
        logic                 err;
        logic [RAW_WIDTH-1:0] raw;
    } front_word_t;

endpackage

[rtl/zacw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zacw_front
// Tick engine: line protocol state machine, bit sampling and parity.
// ----------------------------------------------------------------------------
module zacw_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           start_request,
    input  logic                           line_level,
    input  logic [zacw_pkg::CFG_WIDTH-1:0] settle_ticks,
    input  logic [zacw_pkg::CFG_WIDTH-1:0] sample_delay_ticks,
    output zacw_pkg::front_word_t          word
);
    import zacw_pkg::*;

    localparam logic [TICK_COUNTER_WIDTH-1:0] CNT_MAX = '1;

    phase_t                          phase_reg, phase_next;
    logic [TICK_COUNTER_WIDTH-1:0]   tick_reg, tick_next, tick_inc;
    logic [BIT_INDEX_WIDTH-1:0]      idx_reg, idx_next, idx_inc;
    logic [BITS_PER_PACKET-1:0]      shift_reg, shift_next, shift_smp, fin_shift;
    logic                            par_reg, par_next, par_smp, fin_par;
    logic [BYTE_WIDTH-1:0]           first_reg, first_next, data;
    logic                            pn_reg, pn_next;
    logic                            es_reg, es_next, err_all;
    logic                            finish;
    logic [CFG_WIDTH-1:0]            settle_lim, delay_lim;
    logic                            settle_hit, delay_hit;

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        par_next   = par_reg;
        first_next = first_reg;
        pn_next    = pn_reg;
        es_next    = es_reg;
        word       = '0;
        finish     = 1'b0;
        fin_shift  = shift_reg;
        fin_par    = par_reg;

        tick_inc   = (tick_reg < CNT_MAX) ? tick_reg + 1'b1 : tick_reg;
        settle_lim = (settle_ticks == '0) ? CFG_WIDTH'(1) : settle_ticks;
        delay_lim  = (sample_delay_ticks == '0) ? CFG_WIDTH'(1) : sample_delay_ticks;
        settle_hit = (CMP_WIDTH'(tick_inc) >= CMP_WIDTH'(settle_lim)) ||
                     (tick_inc == CNT_MAX);
        delay_hit  = (CMP_WIDTH'(tick_inc) >= CMP_WIDTH'(delay_lim)) ||
                     (tick_inc == CNT_MAX);
        shift_smp  = {shift_reg[BITS_PER_PACKET-2:0], line_level};
        par_smp    = par_reg ^ line_level;
        idx_inc    = idx_reg + 1'b1;

        case (phase_reg)
            PH_SETTLE:
            begin
                tick_next = tick_inc;
                if (settle_hit)
                    phase_next = PH_SYNC_HIGH;
            end
            PH_SYNC_HIGH:
            begin
                if (!line_level)
                    phase_next = PH_SYNC_LOW;
            end
            PH_SYNC_LOW:
            begin
                if (line_level)
                begin
                    idx_next   = '0;
                    shift_next = '0;
                    par_next   = 1'b0;
                    phase_next = PH_BIT_HIGH;
                end
            end
            PH_BIT_HIGH:
            begin
                if (!line_level)
                begin
                    tick_next  = '0;
                    phase_next = PH_DELAY;
                end
            end
            PH_DELAY:
            begin
                tick_next = tick_inc;
                if (delay_hit)
                begin
                    shift_next = shift_smp;
                    par_next   = par_smp;
                    idx_next   = idx_inc;
                    fin_shift  = shift_smp;
                    fin_par    = par_smp;
                    if (!line_level)
                        phase_next = PH_BIT_LOW;
                    else if (idx_inc >= BIT_INDEX_WIDTH'(BITS_PER_PACKET))
                        finish = 1'b1;
                    else
                        phase_next = PH_BIT_HIGH;
                end
            end
            PH_BIT_LOW:
            begin
                if (line_level)
                begin
                    if (idx_reg >= BIT_INDEX_WIDTH'(BITS_PER_PACKET))
                        finish = 1'b1;
                    else
                        phase_next = PH_BIT_HIGH;
                end
            end
            default:
            begin
                // Idle, and any stray code recovers here
                phase_next = PH_IDLE;
                if (start_request)
                begin
                    tick_next  = '0;
                    pn_next    = 1'b0;
                    es_next    = 1'b0;
                    phase_next = PH_SETTLE;
                end
            end
        endcase

        data    = BYTE_WIDTH'(fin_shift >> 1);
        err_all = es_reg | fin_par;
        if (finish)
        begin
            if (!pn_reg)
            begin
                first_next = data;
                es_next    = err_all;
                pn_next    = 1'b1;
                phase_next = PH_SYNC_HIGH;
            end
            else
            begin
                word.done  = 1'b1;
                word.err   = err_all;
                word.raw   = {first_reg, data};
                phase_next = PH_IDLE;
                pn_next    = 1'b0;
                es_next    = 1'b0;
            end
        end
        word.power = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            idx_reg   <= '0;
            shift_reg <= '0;
            par_reg   <= 1'b0;
            first_reg <= '0;
            pn_reg    <= 1'b0;
            es_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
            par_reg   <= par_next;
            first_reg <= first_next;
            pn_reg    <= pn_next;
            es_reg    <= es_next;
        end
    end

endmodule

[rtl/zacw_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zacw_queue
// Short register queue that decouples the tick engine from the back end.
// ----------------------------------------------------------------------------
module zacw_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    input  zacw_pkg::front_word_t wr_word,
    output logic                  q_full,
    input  logic                  rd,
    output zacw_pkg::front_word_t rd_word,
    output logic                  q_empty
);
    import zacw_pkg::*;

    front_word_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wp_reg, rp_reg;
    logic [QCNT_WIDTH-1:0] cnt_reg;
    logic                  do_wr, do_rd;

    assign q_full  = (cnt_reg == QCNT_WIDTH'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_word = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= (rp_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

[rtl/zacw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zacw_back
// Four-stage elastic pipeline that turns the raw value into centidegrees.
// ----------------------------------------------------------------------------
module zacw_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  zacw_pkg::front_word_t               in_word,
    input  logic                                in_empty,
    output logic                                in_pop,
    output logic                                empty,
    input  logic                                pop,
    output logic                                power_enable,
    output logic                                done_res,
    output logic                                parity_error,
    output logic [zacw_pkg::RAW_WIDTH-1:0]      raw_value,
    output logic signed [zacw_pkg::TEMP_WIDTH-1:0] temperature_centi
);
    import zacw_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    front_word_t             w1_reg, w2_reg, w3_reg, w4_reg;
    logic [PROD1_WIDTH-1:0]  p1_reg, p2_reg;
    logic [WHOLE_WIDTH-1:0]  n1_reg, n2_reg, n3_reg;
    logic [QUOT_WIDTH-1:0]   q0_reg, q3_reg;
    logic [TEMP_WIDTH-1:0]   t4_reg;

    logic [PROD2_WIDTH-1:0]  prod2;
    logic [PROD1_WIDTH:0]    q0_times, rem;
    logic [QUOT_WIDTH-1:0]   q_fix;
    logic [TEMP_WIDTH-1:0]   temp_sum;

    assign rdy4   = !v4_reg || pop;
    assign rdy3   = !v3_reg || rdy4;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || rdy2;
    assign in_pop = !in_empty && rdy1;

    // Reciprocal estimate, then one compare and subtract
    assign prod2    = PROD2_WIDTH'(p1_reg) * PROD2_WIDTH'(RECIP);
    assign q0_times = ((PROD1_WIDTH + 1)'(q0_reg) << DIV_SHIFT) - (PROD1_WIDTH + 1)'(q0_reg);
    assign rem      = (PROD1_WIDTH + 1)'(p2_reg) - q0_times;
    assign q_fix    = q0_reg + QUOT_WIDTH'(rem >= DIVISOR);
    assign temp_sum = TEMP_WIDTH'(n3_reg) + TEMP_WIDTH'(q3_reg) - OFFSET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_pop;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_pop)
        begin
            w1_reg <= in_word;
            p1_reg <= PROD1_WIDTH'(in_word.raw) * SPAN_FRAC;
            n1_reg <= (WHOLE_WIDTH'(in_word.raw) << 3) + WHOLE_WIDTH'(in_word.raw);
        end
        if (rdy2 && v1_reg)
        begin
            w2_reg <= w1_reg;
            n2_reg <= n1_reg;
            p2_reg <= p1_reg;
            q0_reg <= prod2[PROD2_WIDTH-1:RECIP_SHIFT];
        end
        if (rdy3 && v2_reg)
        begin
            w3_reg <= w2_reg;
            n3_reg <= n2_reg;
            q3_reg <= q_fix;
        end
        if (rdy4 && v3_reg)
        begin
            w4_reg <= w3_reg;
            // Hold temperature at zero on ticks without a result
            t4_reg <= w3_reg.done ? temp_sum : '0;
        end
    end

    assign empty             = !v4_reg;
    assign power_enable      = w4_reg.power;
    assign done_res          = w4_reg.done;
    assign parity_error      = w4_reg.err;
    assign raw_value         = w4_reg.raw;
    assign temperature_centi = $signed(t4_reg);

endmodule

[rtl/zacwire_temperature_receiver_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zacwire_temperature_receiver_core
// Single-wire sensor receiver: powers the sensor, reads two parity-checked
// packets and reports the raw word and the temperature in centidegrees.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  tick in   | push / full        | start_request, line_level
//  result    | empty / pop        | power_enable, done_res, parity_error,
//            |                    | raw_value, temperature_centi
//  config    | cfg_write          | cfg_index, cfg_data
//
//  One tick word is accepted per cycle while full is low; every tick gives
//  one result word. The state machine steps once per accepted tick; the
//  result word reaches the result ports through the queue write and then
//  four pipeline stages, the queue read sharing an edge with stage one.
//  full rises only when the four-entry queue fills while the result side
//  stalls; the back pipeline stalls stage by stage from pop.
//  Reset clears the state machine, queue and pipeline; registers return to 60.
// ----------------------------------------------------------------------------
module zacwire_temperature_receiver_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic                                   start_request,
    input  logic                                   line_level,
    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   power_enable,
    output logic                                   done_res,
    output logic                                   parity_error,
    output logic [zacw_pkg::RAW_WIDTH-1:0]         raw_value,
    output logic signed [zacw_pkg::TEMP_WIDTH-1:0] temperature_centi,
    input  logic                                   cfg_write,
    input  logic [zacw_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [zacw_pkg::CFG_WIDTH-1:0]         cfg_data
);
    import zacw_pkg::*;

    logic [CFG_WIDTH-1:0] settle_reg, delay_reg;
    front_word_t          f_word, q_word;
    logic                 accept, q_empty, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_RESET;
            delay_reg  <= SAMPLE_DELAY_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SETTLE:       settle_reg <= cfg_data;
                REG_SAMPLE_DELAY: delay_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign accept = push && !full;

    zacw_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .start_request      (start_request),
        .line_level         (line_level),
        .settle_ticks       (settle_reg),
        .sample_delay_ticks (delay_reg),
        .word               (f_word)
    );

    zacw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (accept),
        .wr_word (f_word),
        .q_full  (full),
        .rd      (q_pop),
        .rd_word (q_word),
        .q_empty (q_empty)
    );

    zacw_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_word           (q_word),
        .in_empty          (q_empty),
        .in_pop            (q_pop),
        .empty             (empty),
        .pop               (pop),
        .power_enable      (power_enable),
        .done_res          (done_res),
        .parity_error      (parity_error),
        .raw_value         (raw_value),
        .temperature_centi (temperature_centi)
    );

endmodule

[rtl/zacw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zacw_checker
// Port-level checks of the receiver's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zacw_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   empty,
    input logic                                   pop,
    input logic                                   power_enable,
    input logic                                   done_res,
    input logic                                   parity_error,
    input logic [zacw_pkg::RAW_WIDTH-1:0]         raw_value,
    input logic signed [zacw_pkg::TEMP_WIDTH-1:0] temperature_centi
);
    import zacw_pkg::*;

    // A completed measurement drops sensor power on the same word
    `ASSERT_IMPLY(a_done_unpowered, clk, rst_n, !empty && done_res, !power_enable)

    // Words without a result carry zero payload
    `ASSERT_IMPLY(a_idle_payload_zero, clk, rst_n, !empty && !done_res, !parity_error && raw_value == '0 && temperature_centi == '0)

    // Temperature never falls below minus the offset
    `ASSERT_IMPLY(a_temp_floor, clk, rst_n, !empty && done_res, temperature_centi >= -$signed(OFFSET))

    // A waiting word holds until taken
    `ASSERT_NEXT(a_hold_stalled, clk, rst_n, !empty && !pop, !empty && $stable(raw_value) && $stable(done_res))

endmodule

bind zacwire_temperature_receiver_core zacw_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .empty             (empty),
    .pop               (pop),
    .power_enable      (power_enable),
    .done_res          (done_res),
    .parity_error      (parity_error),
    .raw_value         (raw_value),
    .temperature_centi (temperature_centi)
);

[bench/tb_zacwire_temperature_receiver_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zacwire_temperature_receiver_core
// Drives line ticks into the single-wire temperature receiver, mostly as
// well-formed two-packet sensor frames built from byte values, with broken
// and noisy frames mixed in. A cycle-free model of the state machine
// predicts the word for every tick, and each word popped from the result
// side is compared field by field. Register settings change between
// phases, with both sides idling at random.
// ----------------------------------------------------------------------------
module tb_zacwire_temperature_receiver_core;
    import zacw_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int ITEM_TARGET    = 1700;
    localparam int ROW_COUNT      = 10;

    localparam logic signed [TEMP_WIDTH-1:0] TEMP_AT_ZERO = -21'sd5000;
    localparam logic signed [TEMP_WIDTH-1:0] TEMP_AT_FULL = 21'sd635302;

    typedef struct packed {
        logic                         power;
        logic                         done;
        logic                         err;
        logic [RAW_WIDTH-1:0]         raw;
        logic signed [TEMP_WIDTH-1:0] temp;
    } tick_result_t;

    typedef struct packed {
        logic                         meas;
        logic                         do_cfg;
        logic [CFG_WIDTH-1:0]         settle;
        logic [CFG_WIDTH-1:0]         delay;
        logic [BYTE_WIDTH-1:0]        b0;
        logic [BYTE_WIDTH-1:0]        b1;
        logic [1:0]                   bad;
        logic                         broken;
        logic [7:0]                   ticks;
        logic                         typed;
        logic                         exp_err;
        logic [RAW_WIDTH-1:0]         exp_raw;
        logic signed [TEMP_WIDTH-1:0] exp_temp;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          push = 1'b0;
    logic                          full;
    logic                          start_request = 1'b0;
    logic                          line_level = 1'b0;
    logic                          empty;
    logic                          pop = 1'b0;
    logic                          power_enable;
    logic                          done_res;
    logic                          parity_error;
    logic [RAW_WIDTH-1:0]          raw_value;
    logic signed [TEMP_WIDTH-1:0]  temperature_centi;
    logic                          cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]    cfg_index = REG_SETTLE;
    logic [CFG_WIDTH-1:0]          cfg_data = '0;

    zacwire_temperature_receiver_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .start_request     (start_request),
        .line_level        (line_level),
        .empty             (empty),
        .pop               (pop),
        .power_enable      (power_enable),
        .done_res          (done_res),
        .parity_error      (parity_error),
        .raw_value         (raw_value),
        .temperature_centi (temperature_centi),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver model state
    phase_t                       rx_phase;
    logic [TICK_COUNTER_WIDTH-1:0] tick_cnt;
    int                           bit_cnt;
    logic [BITS_PER_PACKET-1:0]   shift_reg;
    logic                         par_acc;
    logic [BYTE_WIDTH-1:0]        first_byte;
    logic                         second_packet;
    logic                         err_seen;
    logic [CFG_WIDTH-1:0]         cfg_settle;
    logic [CFG_WIDTH-1:0]         cfg_delay;

    tick_result_t expected_words[$];
    tick_result_t typed_word;
    tick_result_t want_word;
    logic         typed_on = 1'b0;
    int           error_count = 0;
    int           sent_ticks = 0;
    int           send_idle_pct = 0;
    int           take_idle_pct = 0;
    int           stall_left = 0;
    int           quiet_cycles = 0;
    stim_row_t    directed_rows [ROW_COUNT];

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int idle_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [BYTE_WIDTH-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return BYTE_WIDTH'($urandom_range(0, 255));
        endcase
    endfunction

    // Saturating count toward limit; zero acts as one.
    function automatic logic count_reached(input logic [CFG_WIDTH-1:0] limit);
        logic [CFG_WIDTH-1:0] lim;
        lim = (limit == '0) ? CFG_WIDTH'(1) : limit;
        if (tick_cnt != '1)
            tick_cnt = tick_cnt + 1'b1;
        return (tick_cnt >= lim) || (tick_cnt == '1);
    endfunction

    function automatic logic close_packet(output logic [RAW_WIDTH-1:0] raw,
                                          output logic err);
        logic [BYTE_WIDTH-1:0] data;
        logic                  e;
        data = shift_reg[BYTE_WIDTH:1];
        e = err_seen | par_acc;
        raw = '0;
        err = 1'b0;
        if (!second_packet)
        begin
            first_byte = data;
            err_seen = e;
            second_packet = 1'b1;
            rx_phase = PH_SYNC_HIGH;
            return 1'b0;
        end
        raw = {first_byte, data};
        err = e;
        rx_phase = PH_IDLE;
        second_packet = 1'b0;
        err_seen = 1'b0;
        return 1'b1;
    endfunction

    function automatic tick_result_t receiver_step(input logic st, input logic ln);
        tick_result_t         r;
        logic                 done;
        logic [RAW_WIDTH-1:0] raw;
        logic                 err;
        longint               t;
        r = '0;
        done = 1'b0;
        raw = '0;
        err = 1'b0;
        case (rx_phase)
            PH_SETTLE:
                if (count_reached(cfg_settle))
                    rx_phase = PH_SYNC_HIGH;
            PH_SYNC_HIGH:
                if (!ln)
                    rx_phase = PH_SYNC_LOW;
            PH_SYNC_LOW:
                if (ln)
                begin
                    bit_cnt = 0;
                    shift_reg = '0;
                    par_acc = 1'b0;
                    rx_phase = PH_BIT_HIGH;
                end
            PH_BIT_HIGH:
                if (!ln)
                begin
                    tick_cnt = '0;
                    rx_phase = PH_DELAY;
                end
            PH_DELAY:
                if (count_reached(cfg_delay))
                begin
                    shift_reg = {shift_reg[BITS_PER_PACKET-2:0], ln};
                    par_acc = par_acc ^ ln;
                    bit_cnt++;
                    if (!ln)
                        rx_phase = PH_BIT_LOW;
                    else if (bit_cnt >= BITS_PER_PACKET)
                        done = close_packet(raw, err);
                    else
                        rx_phase = PH_BIT_HIGH;
                end
            PH_BIT_LOW:
                if (ln)
                begin
                    if (bit_cnt >= BITS_PER_PACKET)
                        done = close_packet(raw, err);
                    else
                        rx_phase = PH_BIT_HIGH;
                end
            default:
            begin
                rx_phase = PH_IDLE;
                if (st)
                begin
                    tick_cnt = '0;
                    second_packet = 1'b0;
                    err_seen = 1'b0;
                    rx_phase = PH_SETTLE;
                end
            end
        endcase
        r.power = (rx_phase != PH_IDLE);
        r.done = done;
        r.err = err;
        r.raw = raw;
        if (done)
        begin
            t = longint'(raw) * 20000 / 2047 - 5000;
            r.temp = t[TEMP_WIDTH-1:0];
        end
        return r;
    endfunction

    // Leaves push high after acceptance; the caller drives it again in the same step.
    task automatic send_tick(input logic st, input logic ln);
        int           gap;
        tick_result_t pred;
        gap = idle_gap(send_idle_pct);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        start_request <= st;
        line_level <= ln;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_ticks++;
        pred = receiver_step(st, ln);
        if (typed_on && typed_word.done == pred.done)
            expected_words.push_back(typed_word);
        else
            expected_words.push_back(pred);
    endtask

    // Start requests only as noise while busy.
    task automatic line_tick(input logic ln);
        logic st;
        st = (rx_phase != PH_IDLE) ? ($urandom_range(0, 1) == 1) : 1'b0;
        send_tick(st, ln);
    endtask

    task automatic hold_line(input logic ln, input int n);
        repeat (n) line_tick(ln);
    endtask

    // Walk the line until the receiver is idle again.
    task automatic finish_measurement();
        while (rx_phase != PH_IDLE)
        begin
            case (rx_phase)
                PH_SYNC_HIGH, PH_BIT_HIGH, PH_DELAY: line_tick(1'b0);
                PH_SYNC_LOW, PH_BIT_LOW:             line_tick(1'b1);
                default:                             line_tick($urandom_range(0, 1) == 1);
            endcase
        end
    endtask

    task automatic send_packet(input logic [BYTE_WIDTH-1:0] data, input logic flip,
                               input int lim, input int hold_at);
        logic [BITS_PER_PACKET-1:0] pkt_bits;
        int                         lo;
        int                         k;
        pkt_bits = {data, ^data ^ flip};
        hold_line(1'b0, $urandom_range(1, 3));
        hold_line(1'b1, $urandom_range(1, 3));
        for (k = BITS_PER_PACKET - 1; k >= 0; k--)
        begin
            // stuck line mid-packet
            if (k == hold_at)
                hold_line($urandom_range(0, 1) == 1, $urandom_range(20, 150));
            if (pkt_bits[k])
            begin
                lo = $urandom_range(1, lim);
                hold_line(1'b0, lo);
                hold_line(1'b1, lim - lo + 1 + $urandom_range(0, 2));
            end
            else
            begin
                hold_line(1'b0, lim + 1 + $urandom_range(0, 2));
                hold_line(1'b1, $urandom_range(1, 3));
            end
        end
    endtask

    task automatic run_measurement(input logic [BYTE_WIDTH-1:0] b0,
                                   input logic [BYTE_WIDTH-1:0] b1,
                                   input logic [1:0] bad, input logic broken);
        int settle_lim;
        int bit_lim;
        int hold0;
        int hold1;
        settle_lim = (cfg_settle == '0) ? 1 : cfg_settle;
        bit_lim = (cfg_delay == '0) ? 1 : cfg_delay;
        hold0 = -1;
        hold1 = -1;
        if (broken)
        begin
            if ($urandom_range(0, 1) == 1)
                hold0 = $urandom_range(0, BITS_PER_PACKET - 1);
            else
                hold1 = $urandom_range(0, BITS_PER_PACKET - 1);
        end
        send_tick(1'b1, $urandom_range(0, 1) == 1);
        repeat (settle_lim) line_tick($urandom_range(0, 1) == 1);
        hold_line(1'b1, $urandom_range(0, 2));
        send_packet(b0, bad[1], bit_lim, hold0);
        send_packet(b1, bad[0], bit_lim, hold1);
        finish_measurement();
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_WIDTH-1:0] settle,
                              input logic [CFG_WIDTH-1:0] delay);
        drain_results();
        cfg_write <= 1'b1;
        cfg_index <= REG_SETTLE;
        cfg_data <= settle;
        @(posedge clk);
        cfg_index <= REG_SAMPLE_DELAY;
        cfg_data <= delay;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_settle = settle;
        cfg_delay = delay;
    endtask

    // Result side: check the word taken at this edge, then pick the next pop.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                want_word = expected_words.pop_front();
                if (power_enable !== want_word.power)
                    report_mismatch($sformatf("power_enable %0b, expected %0b",
                                              power_enable, want_word.power));
                if (done_res !== want_word.done)
                    report_mismatch($sformatf("done_res %0b, expected %0b",
                                              done_res, want_word.done));
                if (parity_error !== want_word.err)
                    report_mismatch($sformatf("parity_error %0b, expected %0b",
                                              parity_error, want_word.err));
                if (raw_value !== want_word.raw)
                    report_mismatch($sformatf("raw_value %h, expected %h",
                                              raw_value, want_word.raw));
                if (temperature_centi !== want_word.temp)
                    report_mismatch($sformatf("temperature_centi %0d, expected %0d",
                                              temperature_centi, want_word.temp));
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else
        begin
            stall_left = idle_gap(take_idle_pct);
            pop <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb_zacwire_temperature_receiver_core: errors");
            $finish;
        end
    end

    initial
    begin
        stim_row_t        row;
        logic [CFG_WIDTH-1:0] s;
        logic [CFG_WIDTH-1:0] d;
        int               i;

        // meas cfg settle delay b0 b1 bad broken ticks | typed err raw temp
        directed_rows[0] = {1'b0, 1'b0, 16'd0, 16'd0, 8'h00, 8'h00, 2'b00, 1'b0, 8'd4,
                            1'b1, 1'b0, 16'h0000, 21'sd0};
        directed_rows[1] = {1'b1, 1'b1, 16'd0, 16'd0, 8'h00, 8'h00, 2'b00, 1'b0, 8'd0,
                            1'b1, 1'b0, 16'h0000, TEMP_AT_ZERO};
        directed_rows[2] = {1'b1, 1'b0, 16'd0, 16'd0, 8'hFF, 8'hFF, 2'b00, 1'b0, 8'd0,
                            1'b1, 1'b0, 16'hFFFF, TEMP_AT_FULL};
        directed_rows[3] = {1'b1, 1'b1, 16'd1, 16'd1, 8'h00, 8'h00, 2'b10, 1'b0, 8'd0,
                            1'b1, 1'b1, 16'h0000, TEMP_AT_ZERO};
        directed_rows[4] = {1'b1, 1'b0, 16'd1, 16'd1, 8'hFF, 8'hFF, 2'b01, 1'b0, 8'd0,
                            1'b1, 1'b1, 16'hFFFF, TEMP_AT_FULL};
        directed_rows[5] = {1'b1, 1'b1, 16'd3, 16'd2, 8'h80, 8'h01, 2'b00, 1'b0, 8'd0,
                            1'b0, 1'b0, 16'h0000, 21'sd0};
        directed_rows[6] = {1'b1, 1'b1, 16'd2, 16'd5, 8'h5A, 8'hA5, 2'b11, 1'b0, 8'd0,
                            1'b0, 1'b0, 16'h0000, 21'sd0};
        directed_rows[7] = {1'b0, 1'b1, 16'd0, 16'hFFFF, 8'h00, 8'h00, 2'b00, 1'b0, 8'd3,
                            1'b1, 1'b0, 16'h0000, 21'sd0};
        directed_rows[8] = {1'b1, 1'b1, 16'd120, 16'd1, 8'h3C, 8'hC3, 2'b00, 1'b0, 8'd0,
                            1'b0, 1'b0, 16'h0000, 21'sd0};
        directed_rows[9] = {1'b1, 1'b1, 16'd4, 16'd3, 8'h12, 8'h34, 2'b00, 1'b1, 8'd0,
                            1'b0, 1'b0, 16'h0000, 21'sd0};

        rx_phase = PH_IDLE;
        tick_cnt = '0;
        bit_cnt = 0;
        shift_reg = '0;
        par_acc = 1'b0;
        first_byte = '0;
        second_packet = 1'b0;
        err_seen = 1'b0;
        cfg_settle = SETTLE_RESET;
        cfg_delay = SAMPLE_DELAY_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        take_idle_pct = 20;
        for (i = 0; i < ROW_COUNT; i++)
        begin
            row = directed_rows[i];
            if (row.do_cfg)
                write_regs(row.settle, row.delay);
            typed_word.power = 1'b0;
            typed_word.done = row.meas;
            typed_word.err = row.exp_err;
            typed_word.raw = row.exp_raw;
            typed_word.temp = row.exp_temp;
            typed_on = row.typed;
            if (row.meas)
                run_measurement(row.b0, row.b1, row.bad, row.broken);
            else
                repeat (row.ticks) send_tick(1'b0, $urandom_range(0, 1) == 1);
            typed_on = 1'b0;
        end

        while (sent_ticks < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:       s = '0;
                1:       s = SETTLE_RESET;
                default: s = CFG_WIDTH'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0:       d = '0;
                1:       d = CFG_WIDTH'($urandom_range(6, 12));
                default: d = CFG_WIDTH'($urandom_range(1, 4));
            endcase
            write_regs(s, d);
            case ($urandom_range(0, 3))
                0: send_idle_pct = 0;
                1: send_idle_pct = 10;
                2: send_idle_pct = 30;
                default: send_idle_pct = 60;
            endcase
            case ($urandom_range(0, 3))
                0: take_idle_pct = 0;
                1: take_idle_pct = 15;
                2: take_idle_pct = 50;
                default: take_idle_pct = 85;
            endcase
            repeat ($urandom_range(2, 6))
            begin
                case ($urandom_range(0, 9))
                    0:
                        run_measurement(pick_byte(), pick_byte(),
                                        2'($urandom_range(0, 3)), 1'b1);
                    1:
                    begin
                        // start followed by line noise
                        send_tick(1'b1, $urandom_range(0, 1) == 1);
                        repeat ($urandom_range(5, 60)) line_tick($urandom_range(0, 1) == 1);
                        finish_measurement();
                    end
                    2:
                        repeat ($urandom_range(1, 8)) send_tick(1'b0, $urandom_range(0, 1) == 1);
                    default:
                        run_measurement(pick_byte(), pick_byte(),
                                        ($urandom_range(0, 3) == 0) ?
                                            2'($urandom_range(1, 3)) : 2'd0,
                                        1'b0);
                endcase
            end
        end

        drain_results();
        if (error_count == 0)
            $display("tb_zacwire_temperature_receiver_core: clean");
        else
            $display("tb_zacwire_temperature_receiver_core: errors");
        $finish;
    end

endmodule
